@@ src/hsv_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared constants, types and helpers for the hsv to rgb converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

    // field widths
    localparam int HUE_W    = 9;
    localparam int CHAN_W   = 8;
    localparam int FRAC_W   = 8;
    localparam int PROD_W   = 16;
    localparam int SECTOR_W = 3;

    // arithmetic constants
    localparam int SECTOR_DEG = 60;
    localparam int FULL_SCALE = 255;
    localparam int SECTORS    = 6;
    localparam int MAX_QUOT   = 8;

    typedef logic [SECTOR_W-1:0] t_sector;

    // sector codes, one per 60 degree span
    localparam t_sector SEC_RED_YEL = 3'd0;
    localparam t_sector SEC_YEL_GRN = 3'd1;
    localparam t_sector SEC_GRN_CYN = 3'd2;
    localparam t_sector SEC_CYN_BLU = 3'd3;
    localparam t_sector SEC_BLU_MAG = 3'd4;
    localparam t_sector SEC_MAG_RED = 3'd5;

    // floor(x / 255) for x up to 255 * 255, by reciprocal add and shift
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] tmp;
        tmp = {1'b0, x} + {9'd0, x[PROD_W-1:CHAN_W]} + 17'd1;
        return tmp[PROD_W-1:CHAN_W];
    endfunction

endpackage

@@ src/hsv_to_rgb_converter_top.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Integer hsv to rgb conversion, 8 bits per channel, in a five stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one pixel request: hue in degrees, saturation and
//   brightness. m_tdata returns red, green and blue for each request, in order.
//   A request is taken when s_tvalid and s_tready are high at a clock edge,
//   a result when m_tvalid and m_tready are high.
// Pipeline: a request passes through all five register stages (hue split,
//   first products, first divide by 255, second products, second divide and
//   channel select) before m_tvalid rises for its result.
// Throughput: one pixel per clock while m_tready stays high.
// Reset: i_rst_n low clears every stage valid bit; no result is pending after.
// Stall: with m_tready low, each stage holds only while the one after it is
//   full, so bubbles close up; s_tready drops once all five stages are full.
// Hues from 360 to 511 act as hue minus 360.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue[8:0], saturation[16:9], brightness[24:17]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int NSTG = 5;

    // stage valid bits and enables
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    // stage a: sector split
    hsv_pkg::t_sector              r_a_sec;
    logic [hsv_pkg::FRAC_W-1:0]    r_a_frac;
    logic [hsv_pkg::CHAN_W-1:0]    r_a_sat;
    logic [hsv_pkg::CHAN_W-1:0]    r_a_val;
    // stage b: first products
    hsv_pkg::t_sector              r_b_sec;
    logic [hsv_pkg::CHAN_W-1:0]    r_b_val;
    logic [hsv_pkg::PROD_W-1:0]    r_b_mq;
    logic [hsv_pkg::PROD_W-1:0]    r_b_mt;
    logic [hsv_pkg::PROD_W-1:0]    r_b_mp;
    // stage c: level factors
    hsv_pkg::t_sector              r_c_sec;
    logic [hsv_pkg::CHAN_W-1:0]    r_c_val;
    logic [hsv_pkg::CHAN_W-1:0]    r_c_p;
    logic [hsv_pkg::CHAN_W-1:0]    r_c_aq;
    logic [hsv_pkg::CHAN_W-1:0]    r_c_at;
    // stage d: second products
    hsv_pkg::t_sector              r_d_sec;
    logic [hsv_pkg::CHAN_W-1:0]    r_d_val;
    logic [hsv_pkg::CHAN_W-1:0]    r_d_p;
    logic [hsv_pkg::PROD_W-1:0]    r_d_mq;
    logic [hsv_pkg::PROD_W-1:0]    r_d_mt;
    // stage e: output
    logic [hsv_pkg::CHAN_W-1:0]    r_e_red;
    logic [hsv_pkg::CHAN_W-1:0]    r_e_green;
    logic [hsv_pkg::CHAN_W-1:0]    r_e_blue;

    // next values
    hsv_pkg::t_sector              n_a_sec;
    logic [hsv_pkg::FRAC_W-1:0]    n_a_frac;
    logic [hsv_pkg::CHAN_W-1:0]    n_c_q_fac;
    logic [hsv_pkg::CHAN_W-1:0]    n_c_t_fac;
    logic [hsv_pkg::CHAN_W-1:0]    n_e_q;
    logic [hsv_pkg::CHAN_W-1:0]    n_e_t;
    logic [hsv_pkg::CHAN_W-1:0]    n_e_red;
    logic [hsv_pkg::CHAN_W-1:0]    n_e_green;
    logic [hsv_pkg::CHAN_W-1:0]    n_e_blue;

    // a stage loads when it is empty or the next one moves on
    always_comb begin
        en[NSTG-1] = ~r_v[NSTG-1] | m_tready;
        for (int i = NSTG-2; i >= 0; i--) begin
            en[i] = ~r_v[i] | en[i+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // hue to sector and fraction
    hsv_hue_split u_split (
        .i_hue    (s_tdata[8:0]),
        .o_sector (n_a_sec),
        .o_frac   (n_a_frac)
    );

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_sec  <= n_a_sec;
            r_a_frac <= n_a_frac;
            r_a_sat  <= s_tdata[16:9];
            r_a_val  <= s_tdata[24:17];
        end
    end

    // products s*f, s*(255-f), v*(255-s)
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_b_sec <= r_a_sec;
            r_b_val <= r_a_val;
            r_b_mq  <= 16'(r_a_sat) * 16'(r_a_frac);
            r_b_mt  <= 16'(r_a_sat) * 16'(8'(hsv_pkg::FULL_SCALE) - r_a_frac);
            r_b_mp  <= 16'(r_a_val) * 16'(8'(hsv_pkg::FULL_SCALE) - r_a_sat);
        end
    end

    // divide by 255 and form the q and t factors
    assign n_c_q_fac = 8'(hsv_pkg::FULL_SCALE) - hsv_pkg::div255(r_b_mq);
    assign n_c_t_fac = 8'(hsv_pkg::FULL_SCALE) - hsv_pkg::div255(r_b_mt);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_c_sec <= r_b_sec;
            r_c_val <= r_b_val;
            r_c_p   <= hsv_pkg::div255(r_b_mp);
            r_c_aq  <= n_c_q_fac;
            r_c_at  <= n_c_t_fac;
        end
    end

    // products v*factor for q and t
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_d_sec <= r_c_sec;
            r_d_val <= r_c_val;
            r_d_p   <= r_c_p;
            r_d_mq  <= 16'(r_c_val) * 16'(r_c_aq);
            r_d_mt  <= 16'(r_c_val) * 16'(r_c_at);
        end
    end

    // final divide and channel select
    assign n_e_q = hsv_pkg::div255(r_d_mq);
    assign n_e_t = hsv_pkg::div255(r_d_mt);

    always_comb begin
        case (r_d_sec)
            hsv_pkg::SEC_RED_YEL: begin
                n_e_red = r_d_val; n_e_green = n_e_t;   n_e_blue = r_d_p;
            end
            hsv_pkg::SEC_YEL_GRN: begin
                n_e_red = n_e_q;   n_e_green = r_d_val; n_e_blue = r_d_p;
            end
            hsv_pkg::SEC_GRN_CYN: begin
                n_e_red = r_d_p;   n_e_green = r_d_val; n_e_blue = n_e_t;
            end
            hsv_pkg::SEC_CYN_BLU: begin
                n_e_red = r_d_p;   n_e_green = n_e_q;   n_e_blue = r_d_val;
            end
            hsv_pkg::SEC_BLU_MAG: begin
                n_e_red = n_e_t;   n_e_green = r_d_p;   n_e_blue = r_d_val;
            end
            default: begin
                n_e_red = r_d_val; n_e_green = r_d_p;   n_e_blue = n_e_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_e_red   <= n_e_red;
            r_e_green <= n_e_green;
            r_e_blue  <= n_e_blue;
        end
    end

    assign m_tvalid = r_v[NSTG-1];
    assign m_tdata  = {r_e_blue, r_e_green, r_e_red};

    // an empty output stage never holds back the input
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output stage");

    // the hue split yields a sector code within range
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_a_sec <= hsv_pkg::SEC_MAG_RED))
        else $error("sector code out of range");

    // the in-sector fraction never exceeds 59*255/60
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_a_frac <= 8'd250))
        else $error("fraction out of range");

    // a stalled full pipe refuses new requests
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v && !m_tready) |-> !s_tready)
        else $error("request accepted while pipeline full and stalled");

endmodule

@@ src/hsv_hue_split.sv @@
// ----------------------------------------------------------------------------
// hsv_hue_split
// Splits a hue angle into its 60 degree sector and the scaled position
// inside that sector.
// ----------------------------------------------------------------------------
module hsv_hue_split (
    input  logic [hsv_pkg::HUE_W-1:0]  i_hue,
    output hsv_pkg::t_sector           o_sector,
    output logic [hsv_pkg::FRAC_W-1:0] o_frac
);

    logic [3:0]                 quot;
    logic [hsv_pkg::HUE_W-1:0]  base;
    logic [hsv_pkg::HUE_W-1:0]  rem9;
    logic [5:0]                 rem;
    logic [9:0]                 rem_x17;

    // quotient by sixty: count the sector boundaries at or below the hue
    always_comb begin
        quot = 4'd0;
        for (int k = 1; k <= hsv_pkg::MAX_QUOT; k++) begin
            if (i_hue >= 9'(k * hsv_pkg::SECTOR_DEG)) begin
                quot = quot + 4'd1;
            end
        end
    end

    // remainder by sixty
    assign base    = 9'(quot) * 9'(hsv_pkg::SECTOR_DEG);
    assign rem9    = i_hue - base;
    assign rem     = rem9[5:0];

    // sector wraps after six spans
    assign o_sector = (quot >= 4'(hsv_pkg::SECTORS)) ?
                      3'(quot - 4'(hsv_pkg::SECTORS)) : 3'(quot);

    // frac = rem * 255 / 60 = rem * 17 / 4
    assign rem_x17 = {rem, 4'b0000} + {4'd0, rem};
    assign o_frac  = rem_x17[9:2];

endmodule
